>>> sv/polygon_vertex_classifier_defines.svh
// assertion macros for the polygon vertex classifier
`ifndef POLYGON_VERTEX_CLASSIFIER_DEFINES_SVH
`define POLYGON_VERTEX_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PVC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pvc_pkg.sv
package pvc_pkg;

    localparam int MAX_VERTICES_DEF = 32;

    // turn direction codes
    localparam logic [1:0] SGN_ZERO = 2'b00;
    localparam logic [1:0] SGN_POS  = 2'b01;
    localparam logic [1:0] SGN_NEG  = 2'b11;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } pt_t;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               last_point;
    } in_t;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic               is_convex;
        logic               is_principal;
        logic               status;
        logic               last_result;
    } out_t;

endpackage

>>> sv/polygon_vertex_classifier.sv
// load: one vertex per cycle; after the last vertex the reference turn is found, then every
// vertex is fetched, multiplied and signed to sort out collinear ones
// principal scan per kept vertex: fetch, a skip past the vertex and its neighbours, and for
// every other vertex tested an index, a read and three orientations of two products and a sign, then emit
// throughput: one polygon at a time; input is held off until the last result transfers
// reset: asynchronous, clears the sequencer and counters; vertex memories are not cleared
`include "polygon_vertex_classifier_defines.svh"

module polygon_vertex_classifier #(
    parameter int MAX_VERTICES = pvc_pkg::MAX_VERTICES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pvc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output pvc_pkg::out_t out_data
);

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_VERTICES);
    localparam logic [CW-1:0] CNT_MIN = CW'(3);

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_MUL1  = 8'b0000_0100,
        S_MUL2  = 8'b0000_1000,
        S_SIGN  = 8'b0001_0000,
        S_NEXTJ = 8'b0010_0000,
        S_JWAIT = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    typedef enum logic [2:0] {
        PH_REF  = 3'b001,
        PH_KEEP = 3'b010,
        PH_PRIN = 3'b100
    } phase_t;

    typedef struct packed {
        logic       convex;
        pvc_pkg::pt_t pt;
    } kept_t;

    state_t         state_reg, state_next;
    phase_t         phase_reg, phase_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  top_reg, top_next;
    logic signed [15:0] top_y_reg, top_y_next;
    logic [CW-1:0]  lim_reg, lim_next;
    logic [CW-1:0]  m_reg, m_next;
    logic [IW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [1:0]     fcnt_reg, fcnt_next;
    logic [1:0]     osel_reg, osel_next;
    logic [1:0]     ref_reg, ref_next;
    logic [1:0]     p1_reg, p1_next;
    logic [1:0]     p2_reg, p2_next;
    logic           cur_cv_reg, cur_cv_next;
    pvc_pkg::pt_t   pt_reg [4];
    pvc_pkg::pt_t   pt_next [4];
    logic signed [33:0] prod1_reg, prod1_next;
    logic signed [33:0] prod2_reg, prod2_next;
    pvc_pkg::out_t  out_reg, out_next;

    // vertex and kept-vertex memories
    pvc_pkg::pt_t   vmem [MAX_VERTICES];
    kept_t          kmem [MAX_VERTICES];
    pvc_pkg::pt_t   vrd_reg;
    kept_t          krd_reg;
    logic           vwr_en, kwr_en;
    logic [IW-1:0]  vwr_addr, kwr_addr, raddr;
    kept_t          kwr_data;

    logic [IW-1:0]  idx_a, idx_c;
    logic           in_xfer, out_xfer;
    logic [CW-1:0]  n_new;
    logic [CW-1:0]  i_ext, i_inc;
    pvc_pkg::pt_t   op_p, op_q, op_r, rd_pt;
    logic signed [16:0] mul_a, mul_b;
    logic signed [34:0] diff;
    logic [1:0]     turn;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT);
    assign out_data  = out_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    // cyclic neighbours of the current vertex
    assign i_ext = CW'(i_reg);
    assign i_inc = i_ext + CW'(1);
    assign idx_a = (i_reg == '0) ? IW'(lim_reg - CW'(1)) : IW'(i_ext - CW'(1));
    assign idx_c = (i_inc == lim_reg) ? '0 : IW'(i_inc);

    // memory ports
    always_ff @(posedge clk)
    begin
        if (vwr_en)
        begin
            vmem[vwr_addr] <= '{x: in_data.point_x, y: in_data.point_y};
        end
        vrd_reg <= vmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (kwr_en)
        begin
            kmem[kwr_addr] <= kwr_data;
        end
        krd_reg <= kmem[raddr];
    end

    assign rd_pt = (phase_reg == PH_PRIN) ? krd_reg.pt : vrd_reg;

    // read address
    always_comb
    begin
        case (state_reg)
            S_FETCH:
            begin
                case (fcnt_reg)
                    2'd0:    raddr = idx_a;
                    2'd1:    raddr = i_reg;
                    default: raddr = idx_c;
                endcase
            end
            S_NEXTJ: raddr = IW'(j_reg);
            default: raddr = i_reg;
        endcase
    end

    // orientation operand select: (prev,cur,next), (a,i,j), (c,a,j), (i,c,j)
    always_comb
    begin
        case (osel_reg)
            2'd1:
            begin
                op_p = pt_reg[0]; op_q = pt_reg[1]; op_r = pt_reg[3];
            end
            2'd2:
            begin
                op_p = pt_reg[2]; op_q = pt_reg[0]; op_r = pt_reg[3];
            end
            2'd3:
            begin
                op_p = pt_reg[1]; op_q = pt_reg[2]; op_r = pt_reg[3];
            end
            default:
            begin
                op_p = pt_reg[0]; op_q = pt_reg[1]; op_r = pt_reg[2];
            end
        endcase
    end

    // shared multiplier operands, one product per cycle
    always_comb
    begin
        if (state_reg == S_MUL1)
        begin
            mul_a = 17'(op_q.x) - 17'(op_p.x);
            mul_b = 17'(op_r.y) - 17'(op_p.y);
        end
        else
        begin
            mul_a = 17'(op_q.y) - 17'(op_p.y);
            mul_b = 17'(op_r.x) - 17'(op_p.x);
        end
    end

    // sign of the cross product
    assign diff = 35'(prod1_reg) - 35'(prod2_reg);
    assign turn = (diff == '0) ? pvc_pkg::SGN_ZERO :
                  (diff[34] ? pvc_pkg::SGN_NEG : pvc_pkg::SGN_POS);

    assign n_new = (count_reg < CNT_MAX) ? count_reg + CW'(1) : count_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        top_next    = top_reg;
        top_y_next  = top_y_reg;
        lim_next    = lim_reg;
        m_next      = m_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        fcnt_next   = fcnt_reg;
        osel_next   = osel_reg;
        ref_next    = ref_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        cur_cv_next = cur_cv_reg;
        pt_next     = pt_reg;
        prod1_next  = prod1_reg;
        prod2_next  = prod2_reg;
        out_next    = out_reg;
        vwr_en      = 1'b0;
        vwr_addr    = IW'(count_reg);
        kwr_en      = 1'b0;
        kwr_addr    = IW'(m_reg);
        kwr_data    = '{convex: (turn == ref_reg), pt: pt_reg[1]};

        case (state_reg)
            S_LOAD:
            begin
                if (in_xfer)
                begin
                    if (count_reg < CNT_MAX)
                    begin
                        vwr_en = 1'b1;
                        if (count_reg == '0 || in_data.point_y > top_y_reg)
                        begin
                            top_next   = IW'(count_reg);
                            top_y_next = in_data.point_y;
                        end
                    end
                    count_next = n_new;
                    if (in_data.last_point)
                    begin
                        count_next = '0;
                        lim_next   = n_new;
                        if (n_new < CNT_MIN)
                        begin
                            top_next   = '0;
                            out_next   = '{vertex_x: '0, vertex_y: '0, is_convex: 1'b0,
                                           is_principal: 1'b0, status: 1'b1,
                                           last_result: 1'b1};
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            phase_next = PH_REF;
                            i_next     = top_next;
                            osel_next  = 2'd0;
                            fcnt_next  = 2'd0;
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            // three reads, data captured in the cycle after each read
            S_FETCH:
            begin
                if (fcnt_reg != 2'd0)
                begin
                    pt_next[fcnt_reg - 2'd1] = rd_pt;
                end
                if (fcnt_reg == 2'd2)
                begin
                    cur_cv_next = krd_reg.convex;
                end
                fcnt_next = fcnt_reg + 2'd1;
                if (fcnt_reg == 2'd3)
                begin
                    fcnt_next = 2'd0;
                    if (phase_reg == PH_PRIN)
                    begin
                        j_next     = '0;
                        state_next = S_NEXTJ;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end

            S_MUL1:
            begin
                prod1_next = mul_a * mul_b;
                state_next = S_MUL2;
            end

            S_MUL2:
            begin
                prod2_next = mul_a * mul_b;
                state_next = S_SIGN;
            end

            S_SIGN:
            begin
                case (phase_reg)
                    PH_REF:
                    begin
                        top_next   = '0;
                        ref_next   = turn;
                        phase_next = PH_KEEP;
                        i_next     = '0;
                        m_next     = '0;
                        state_next = S_FETCH;
                    end
                    PH_KEEP:
                    begin
                        if (turn != pvc_pkg::SGN_ZERO)
                        begin
                            kwr_en = 1'b1;
                            m_next = m_reg + CW'(1);
                        end
                        state_next = S_FETCH;
                        if (i_inc == lim_reg)
                        begin
                            if (m_next < CNT_MIN)
                            begin
                                out_next   = '{vertex_x: '0, vertex_y: '0, is_convex: 1'b0,
                                               is_principal: 1'b0, status: 1'b1,
                                               last_result: 1'b1};
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                phase_next = PH_PRIN;
                                lim_next   = m_next;
                                i_next     = '0;
                                osel_next  = 2'd1;
                            end
                        end
                        else
                        begin
                            i_next = IW'(i_inc);
                        end
                    end
                    default:
                    begin
                        state_next = S_MUL1;
                        case (osel_reg)
                            2'd1:
                            begin
                                p1_next   = turn;
                                osel_next = 2'd2;
                            end
                            2'd2:
                            begin
                                p2_next   = turn;
                                osel_next = 2'd3;
                            end
                            default:
                            begin
                                osel_next = 2'd1;
                                if (p1_reg == p2_reg && p2_reg == turn)
                                begin
                                    out_next   = '{vertex_x: pt_reg[1].x,
                                                   vertex_y: pt_reg[1].y,
                                                   is_convex: cur_cv_reg,
                                                   is_principal: 1'b0, status: 1'b0,
                                                   last_result: (i_inc == lim_reg)};
                                    state_next = S_EMIT;
                                end
                                else
                                begin
                                    j_next     = j_reg + CW'(1);
                                    state_next = S_NEXTJ;
                                end
                            end
                        endcase
                    end
                endcase
            end

            // scan the other kept vertices
            S_NEXTJ:
            begin
                if (j_reg == lim_reg)
                begin
                    out_next   = '{vertex_x: pt_reg[1].x, vertex_y: pt_reg[1].y,
                                   is_convex: cur_cv_reg, is_principal: 1'b1,
                                   status: 1'b0, last_result: (i_inc == lim_reg)};
                    state_next = S_EMIT;
                end
                else if (j_reg == CW'(idx_a) || j_reg == i_ext || j_reg == CW'(idx_c))
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    state_next = S_JWAIT;
                end
            end

            S_JWAIT:
            begin
                pt_next[3] = krd_reg.pt;
                osel_next  = 2'd1;
                state_next = S_MUL1;
            end

            S_EMIT:
            begin
                if (out_xfer)
                begin
                    if (out_reg.last_result)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next     = IW'(i_inc);
                        fcnt_next  = 2'd0;
                        state_next = S_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            phase_reg <= PH_REF;
            count_reg <= '0;
            top_reg   <= '0;
            ref_reg   <= pvc_pkg::SGN_ZERO;
            lim_reg   <= '0;
            m_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            fcnt_reg  <= '0;
            osel_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            ref_reg   <= ref_next;
            lim_reg   <= lim_next;
            m_reg     <= m_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            fcnt_reg  <= fcnt_next;
            osel_reg  <= osel_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        top_y_reg  <= top_y_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        cur_cv_reg <= cur_cv_next;
        pt_reg     <= pt_next;
        prod1_reg  <= prod1_next;
        prod2_reg  <= prod2_next;
        out_reg    <= out_next;
    end

    `PVC_ASSERT_NOW(a_no_overlap, in_ready, !out_valid, "input and output open together")
    `PVC_ASSERT_NOW(a_err_last, out_valid && out_data.status, out_data.last_result,
        "error result not marked last")
    `PVC_ASSERT_NEXT(a_last_reload, out_xfer && out_data.last_result, in_ready,
        "block not ready after last result")
    `PVC_ASSERT_NOW(a_kept_enough, state_reg == S_NEXTJ, lim_reg >= CNT_MIN,
        "principal scan with fewer than three vertices")
    `PVC_ASSERT_NEXT(a_load_cleared, out_xfer && out_data.last_result,
        count_reg == '0 && top_reg == '0, "load state not cleared at end of run")

endmodule

>>> tb/polygon_vertex_classifier_tb.sv
`timescale 1ns / 100ps

module polygon_vertex_classifier_tb;

    localparam int NVERT = pvc_pkg::MAX_VERTICES_DEF;

    // polygon predictor and queue of expected vertex results
    class poly_scoreboard;
        logic signed [15:0] vx[NVERT];
        logic signed [15:0] vy[NVERT];
        int unsigned        count;
        int unsigned        top;
        pvc_pkg::out_t      expected_q[$];
        int                 mismatches;
        int                 checked;
        int                 polygons;

        function new();
            count = 0;
            top = 0;
            mismatches = 0;
            checked = 0;
            polygons = 0;
        endfunction

        function int turn(longint ax, longint ay, longint bx, longint by,
                          longint cx, longint cy);
            longint d;
            d = bx * cy + ax * by + cx * ay - ay * bx - ax * cy - by * cx;
            return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
        endfunction

        function void push_error();
            pvc_pkg::out_t r;
            r = '0;
            r.status = 1'b1;
            r.last_result = 1'b1;
            expected_q = {expected_q, r};
        endfunction

        // note an accepted vertex; a last vertex yields the polygon's results
        function void note_input(pvc_pkg::in_t d);
            logic signed [15:0] kx[NVERT];
            logic signed [15:0] ky[NVERT];
            logic               kc[NVERT];
            int                 t[NVERT];
            int                 ref_turn;
            int unsigned        n, m, a, c;
            logic               principal;
            int                 p1, p2, p3;
            pvc_pkg::out_t      r;
            if (count < NVERT)
            begin
                vx[count] = d.point_x;
                vy[count] = d.point_y;
                if (count == 0 || d.point_y > vy[top])
                    top = count;
                count++;
            end
            if (!d.last_point)
                return;
            polygons++;
            n = count;
            count = 0;
            if (n < 3)
            begin
                top = 0;
                push_error();
                return;
            end
            for (int unsigned i = 0; i < n; i++)
            begin
                a = (i + n - 1) % n;
                c = (i + 1) % n;
                t[i] = turn(vx[a], vy[a], vx[i], vy[i], vx[c], vy[c]);
            end
            ref_turn = t[top];
            top = 0;
            // drop collinear vertices
            m = 0;
            for (int unsigned i = 0; i < n; i++)
            begin
                if (t[i] != 0)
                begin
                    kx[m] = vx[i];
                    ky[m] = vy[i];
                    kc[m] = (t[i] == ref_turn);
                    m++;
                end
            end
            if (m < 3)
            begin
                push_error();
                return;
            end
            // principal test against every kept vertex but the vertex and its neighbours
            for (int unsigned i = 0; i < m; i++)
            begin
                a = (i + m - 1) % m;
                c = (i + 1) % m;
                principal = 1'b1;
                for (int unsigned j = 0; j < m; j++)
                begin
                    if (j == a || j == i || j == c)
                        continue;
                    p1 = turn(kx[a], ky[a], kx[i], ky[i], kx[j], ky[j]);
                    p2 = turn(kx[c], ky[c], kx[a], ky[a], kx[j], ky[j]);
                    p3 = turn(kx[i], ky[i], kx[c], ky[c], kx[j], ky[j]);
                    if (p1 == p2 && p2 == p3)
                    begin
                        principal = 1'b0;
                        break;
                    end
                end
                r.vertex_x = kx[i];
                r.vertex_y = ky[i];
                r.is_convex = kc[i];
                r.is_principal = principal;
                r.status = 1'b0;
                r.last_result = (i + 1 == m);
                expected_q = {expected_q, r};
            end
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(pvc_pkg::out_t got);
            pvc_pkg::out_t exp_r;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d cv=%0b pr=%0b st=%0b last=%0b",
                             got.vertex_x, got.vertex_y, got.is_convex,
                             got.is_principal, got.status, got.last_result);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.vertex_x !== exp_r.vertex_x || got.vertex_y !== exp_r.vertex_y
                || got.is_convex !== exp_r.is_convex
                || got.is_principal !== exp_r.is_principal
                || got.status !== exp_r.status || got.last_result !== exp_r.last_result)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch exp x=%0d y=%0d cv=%0b pr=%0b st=%0b last=%0b",
                             exp_r.vertex_x, exp_r.vertex_y, exp_r.is_convex,
                             exp_r.is_principal, exp_r.status, exp_r.last_result);
                    $display("         got x=%0d y=%0d cv=%0b pr=%0b st=%0b last=%0b",
                             got.vertex_x, got.vertex_y, got.is_convex,
                             got.is_principal, got.status, got.last_result);
                end
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    pvc_pkg::in_t   in_data;
    logic           out_valid;
    logic           out_ready;
    pvc_pkg::out_t  out_data;

    poly_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             items_sent;

    polygon_vertex_classifier i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, check on every transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always
    begin
        logic           v;
        logic           r;
        pvc_pkg::out_t  d;
        @(negedge clk);
        v = out_valid;
        r = out_ready;
        d = out_data;
        @(posedge clk);
        if (rst_n && v === 1'b1 && r === 1'b1)
            sb.check_result(d);
    end

    // vertex transfer with optional idle cycles before it
    task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic last);
        pvc_pkg::in_t d;
        logic rdy;
        d.point_x = x;
        d.point_y = y;
        d.last_point = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end
        while (rdy !== 1'b1);
        sb.note_input(d);
        items_sent++;
    endtask

    // random polygon: small box gives collinear and nested cases, wide box toggles all bits
    task automatic send_random_polygon(input int n, input bit wide);
        int span;
        span = $urandom_range(3, 12);
        for (int k = 0; k < n; k++)
        begin
            if (wide)
                send_vertex(16'($urandom), 16'($urandom), k == n - 1);
            else
                send_vertex(16'($urandom_range(0, 2 * span) - span),
                            16'($urandom_range(0, 2 * span) - span), k == n - 1);
        end
    endtask

    // sender goes idle until every pending result is out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int n;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        items_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // triangle at the coordinate extremes
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b1);
        // too few vertices
        send_vertex(16'sd5, 16'sd5, 1'b1);
        send_vertex(16'sd1, 16'sd2, 1'b0);
        send_vertex(16'sd3, 16'sd4, 1'b1);
        // all collinear leaves nothing
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd1, 16'sd1, 1'b0);
        send_vertex(16'sd2, 16'sd2, 1'b1);
        // top vertex collinear on a tied top edge: zero reference turn
        send_vertex(16'sd0, 16'sd4, 1'b0);
        send_vertex(16'sd4, 16'sd4, 1'b0);
        send_vertex(16'sd4, 16'sd0, 1'b0);
        send_vertex(-16'sd4, 16'sd0, 1'b0);
        send_vertex(-16'sd4, 16'sd4, 1'b1);
        // concave pentagon with a non-principal vertex
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd6, 16'sd0, 1'b0);
        send_vertex(16'sd3, 16'sd2, 1'b0);
        send_vertex(16'sd6, 16'sd6, 1'b0);
        send_vertex(16'sd0, 16'sd6, 1'b1);

        // random polygons over idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            while (items_sent < 19 + (ph + 1) * 90)
            begin
                n = ($urandom_range(99) < 8) ? $urandom_range(1, 2) : $urandom_range(3, 12);
                send_random_polygon(n, $urandom_range(99) < 20);
            end
            // hold the sender until every pending result is out
            if (ph == 1)
                wait_drained();
        end
        // one polygon past the vertex limit
        send_random_polygon(NVERT + 3, 1'b0);

        wait_drained();
        repeat (200) @(posedge clk);
        $display("covered %0d vertices in %0d polygons, %0d results checked",
                 items_sent, sb.polygons, sb.checked);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_q.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/pvc_pkg.sv
sv/polygon_vertex_classifier.sv
tb/polygon_vertex_classifier_tb.sv
